// ===== sv/remote_command_byte_parser_macros.svh =====
// ---------------------------------------------------------------------------
// Remote command byte parser assertion macros
// Shared assertion forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef REMOTE_COMMAND_BYTE_PARSER_MACROS_SVH
`define REMOTE_COMMAND_BYTE_PARSER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RCBP_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define RCBP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Implication that is also checked while reset is applied.
`define RCBP_ASSERT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== sv/rcbp_pkg.sv =====
// ---------------------------------------------------------------------------
// Remote command byte parser package
// Character codes, payload types and the packet result record.
// ---------------------------------------------------------------------------
package rcbp_pkg;

   localparam int PACKET_DEPTH_DEFAULT = 50;

   localparam logic [7:0] CH_STEER      = 8'h4B;
   localparam logic [7:0] CH_JOY_A      = 8'h49;
   localparam logic [7:0] CH_JOY_B      = 8'h4A;
   localparam logic [7:0] CH_DIR_FIRST  = 8'h41;
   localparam logic [7:0] CH_DIR_LAST   = 8'h48;
   localparam logic [7:0] CH_DIR_FWD    = 8'h41;
   localparam logic [7:0] CH_DIR_BACK   = 8'h45;
   localparam logic [7:0] CH_SPIN_RIGHT = 8'h43;
   localparam logic [7:0] CH_SPIN_LEFT  = 8'h47;
   localparam logic [7:0] CH_RAW_LAST   = 8'h08;
   localparam logic [7:0] CH_FAST       = 8'h58;
   localparam logic [7:0] CH_SLOW       = 8'h59;
   localparam logic [7:0] CH_OPEN       = 8'h7B;
   localparam logic [7:0] CH_CLOSE      = 8'h7D;
   localparam logic [7:0] CH_REPORT     = 8'h50;
   localparam logic [7:0] CH_NOPARAM    = 8'h23;
   localparam logic [7:0] CH_ID_FIRST   = 8'h30;
   localparam logic [7:0] CH_ID_LAST    = 8'h37;
   localparam logic [7:0] CH_DIGIT_ZERO = 8'h30;

   localparam logic signed [7:0] SPEED_UP   = 8'sd100;
   localparam logic signed [7:0] SPEED_DOWN = -8'sd100;

   typedef struct packed {
      logic [7:0] rx_byte;
   } req_payload_type;

   typedef struct packed {
      logic               turn_mode;
      logic [3:0]         direction;
      logic               rotate_left;
      logic               rotate_right;
      logic signed [7:0]  speed_delta;
      logic               report_request;
      logic               param_valid;
      logic [2:0]         param_index;
      logic signed [31:0] param_value;
      logic               packet_overflow;
   } rsp_payload_type;

   typedef struct packed {
      logic               report_request;
      logic               param_valid;
      logic [2:0]         param_index;
      logic signed [31:0] param_value;
      logic               packet_overflow;
   } pkt_result_type;

endpackage

// ===== sv/rcbp_chan_if.sv =====
// ---------------------------------------------------------------------------
// Remote command byte parser channel
// Valid/ready channel carrying one payload word per transaction.
// ---------------------------------------------------------------------------
interface rcbp_chan_if #(
   parameter type payload_type = logic [7:0]
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/rcbp_packet.sv =====
// ---------------------------------------------------------------------------
// Remote command byte parser packet collector
// Tracks the brace-framed parameter packet and builds its decimal value.
// ---------------------------------------------------------------------------
module rcbp_packet #(
   parameter int PACKET_DEPTH = rcbp_pkg::PACKET_DEPTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic [7:0]              rx_byte,
   output rcbp_pkg::pkt_result_type result
);
   localparam int CW = $clog2(PACKET_DEPTH + 1);

   logic               collecting_ff, collecting_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [7:0]         id_ff, id_in;
   logic [7:0]         third_ff, third_in;
   logic signed [31:0] accum_ff, accum_in;
   logic               ovf_ff, ovf_in;

   logic               is_close;
   logic               in_packet;
   logic signed [35:0] acc_ext;
   logic signed [35:0] digit;
   logic signed [35:0] horner;
   logic signed [31:0] horner_sat;

   assign is_close  = (rx_byte == rcbp_pkg::CH_CLOSE);
   assign in_packet = collecting_ff | (rx_byte == rcbp_pkg::CH_OPEN);

   // Multiply by ten as two shifts, then add the digit and clamp to 32 bits.
   assign acc_ext = 36'(accum_ff);
   assign digit   = 36'($signed({1'b0, rx_byte})) - 36'($signed({1'b0, rcbp_pkg::CH_DIGIT_ZERO}));
   assign horner  = (acc_ext <<< 3) + (acc_ext <<< 1) + digit;

   always_comb begin
      if (horner[35:31] == 5'b00000 || horner[35:31] == 5'b11111) begin
         horner_sat = horner[31:0];
      end else if (horner[35]) begin
         horner_sat = {1'b1, 31'd0};
      end else begin
         horner_sat = {1'b0, {31{1'b1}}};
      end
   end

   always_comb begin
      result = '0;
      if (is_close) begin
         result.packet_overflow = ovf_ff;
         if (third_ff == rcbp_pkg::CH_REPORT) begin
            result.report_request = 1'b1;
         end else if (id_ff != rcbp_pkg::CH_NOPARAM && id_ff >= rcbp_pkg::CH_ID_FIRST &&
                      id_ff <= rcbp_pkg::CH_ID_LAST) begin
            result.param_valid = 1'b1;
            result.param_index = id_ff[2:0];
            result.param_value = accum_ff;
         end
      end
   end

   always_comb begin
      collecting_in = collecting_ff;
      count_in      = count_ff;
      id_in         = id_ff;
      third_in      = third_ff;
      accum_in      = accum_ff;
      ovf_in        = ovf_ff;
      if (step) begin
         if (is_close) begin
            collecting_in = 1'b0;
            count_in      = '0;
            id_in         = '0;
            third_in      = '0;
            accum_in      = '0;
            ovf_in        = 1'b0;
         end else if (in_packet) begin
            collecting_in = 1'b1;
            if (count_ff < CW'(PACKET_DEPTH)) begin
               if (count_ff == CW'(1)) id_in = rx_byte;
               if (count_ff == CW'(3)) third_in = rx_byte;
               if (count_ff >= CW'(3)) accum_in = horner_sat;
               count_in = count_ff + CW'(1);
            end else begin
               ovf_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         collecting_ff <= 1'b0;
         count_ff      <= '0;
         id_ff         <= '0;
         third_ff      <= '0;
         accum_ff      <= '0;
         ovf_ff        <= 1'b0;
      end else begin
         collecting_ff <= collecting_in;
         count_ff      <= count_in;
         id_ff         <= id_in;
         third_ff      <= third_in;
         accum_ff      <= accum_in;
         ovf_ff        <= ovf_in;
      end
   end
endmodule

// ===== sv/remote_command_byte_parser.sv =====
// ---------------------------------------------------------------------------
// Remote command byte parser
// Decodes drive commands and brace-framed parameter packets, one byte each.
// ---------------------------------------------------------------------------
// Every accepted byte produces exactly one response transaction. A byte is
// held in an input register, decoded and folded into the packet value in a
// single pass, and the response sits in an output register. The response is
// offered from that output register after its byte moves on from the input
// register, and a new byte can be taken on every clock while the response
// side keeps up. Throughput is one byte per cycle while the response side
// keeps up, because the one multiply-by-ten-and-add step of the packet value,
// which lies between the byte register and the packet value register, is
// combinational. Packets longer than PACKET_DEPTH bytes keep their first
// PACKET_DEPTH bytes and report packet_overflow at the closing brace.
module remote_command_byte_parser #(
   parameter int PACKET_DEPTH = rcbp_pkg::PACKET_DEPTH_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   rcbp_chan_if.sink   req_ch,
   rcbp_chan_if.source rsp_ch
);
   logic       byte_valid_ff, byte_valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       steer_ff, steer_in;
   logic       spin_left_ff, spin_left_in;
   logic       spin_right_ff, spin_right_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rcbp_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   logic [3:0]         direction;
   logic signed [7:0]  speed_delta;
   logic               advance;
   logic               step;
   logic               req_take;
   rcbp_pkg::pkt_result_type pkt_result;

   assign advance  = !rsp_valid_ff || rsp_ch.ready;
   assign step     = byte_valid_ff && advance;
   assign req_ch.ready = !byte_valid_ff || advance;
   assign req_take = req_ch.valid && req_ch.ready;

   rcbp_packet #(
      .PACKET_DEPTH(PACKET_DEPTH)
   ) u_packet (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (byte_ff),
      .result  (pkt_result)
   );

   // The mode byte takes effect before the same byte is decoded.
   always_comb begin
      steer_in      = steer_ff;
      spin_left_in  = spin_left_ff;
      spin_right_in = spin_right_ff;
      if (byte_ff == rcbp_pkg::CH_STEER) begin
         steer_in = 1'b1;
      end else if (byte_ff == rcbp_pkg::CH_JOY_A || byte_ff == rcbp_pkg::CH_JOY_B) begin
         steer_in = 1'b0;
      end
      direction = 4'd0;
      if (steer_in) begin
         spin_left_in  = (byte_ff == rcbp_pkg::CH_SPIN_LEFT);
         spin_right_in = (byte_ff == rcbp_pkg::CH_SPIN_RIGHT);
         if (byte_ff == rcbp_pkg::CH_DIR_FWD || byte_ff == rcbp_pkg::CH_DIR_BACK) begin
            direction = byte_ff[3:0];
         end
      end else begin
         if ((byte_ff >= rcbp_pkg::CH_DIR_FIRST && byte_ff <= rcbp_pkg::CH_DIR_LAST) ||
             byte_ff <= rcbp_pkg::CH_RAW_LAST) begin
            direction = byte_ff[3:0];
         end
      end
      if (!step) begin
         steer_in      = steer_ff;
         spin_left_in  = spin_left_ff;
         spin_right_in = spin_right_ff;
      end
   end

   always_comb begin
      speed_delta = 8'sd0;
      if (byte_ff == rcbp_pkg::CH_FAST) speed_delta = rcbp_pkg::SPEED_UP;
      if (byte_ff == rcbp_pkg::CH_SLOW) speed_delta = rcbp_pkg::SPEED_DOWN;
   end

   always_comb begin
      rsp_data_in                 = rsp_data_ff;
      rsp_data_in.turn_mode       = steer_in;
      rsp_data_in.direction       = direction;
      rsp_data_in.rotate_left     = spin_left_in;
      rsp_data_in.rotate_right    = spin_right_in;
      rsp_data_in.speed_delta     = speed_delta;
      rsp_data_in.report_request  = pkt_result.report_request;
      rsp_data_in.param_valid     = pkt_result.param_valid;
      rsp_data_in.param_index     = pkt_result.param_index;
      rsp_data_in.param_value     = pkt_result.param_value;
      rsp_data_in.packet_overflow = pkt_result.packet_overflow;
   end

   always_comb begin
      byte_in       = req_take ? req_ch.payload.rx_byte : byte_ff;
      byte_valid_in = req_take ? 1'b1 : (step ? 1'b0 : byte_valid_ff);
      rsp_valid_in  = step ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         steer_ff      <= 1'b0;
         spin_left_ff  <= 1'b0;
         spin_right_ff <= 1'b0;
      end else begin
         byte_valid_ff <= byte_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         steer_ff      <= steer_in;
         spin_left_ff  <= spin_left_in;
         spin_right_ff <= spin_right_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      if (step) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;
endmodule

// ===== sv/rcbp_checker.sv =====
// ---------------------------------------------------------------------------
// Remote command byte parser port checker
// Watches the top-level response channel and flags inconsistent responses.
// ---------------------------------------------------------------------------
`include "remote_command_byte_parser_macros.svh"

module rcbp_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input rcbp_pkg::rsp_payload_type rsp_payload
);
   // A response is never offered in the cycle right after reset.
   `RCBP_ASSERT_ALWAYS(a_idle_after_reset, $past(reset) && !reset, !rsp_valid, "response valid after reset")

   // A stalled response keeps its contents.
   `RCBP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "stalled response changed")

   // A closing brace reports a request or a parameter, never both.
   `RCBP_ASSERT_IMPL(a_close_exclusive, rsp_valid, !(rsp_payload.report_request && rsp_payload.param_valid), "report and parameter together")

   // Without a parameter assignment the index and value read as zero.
   `RCBP_ASSERT_IMPL(a_param_zero, rsp_valid && !rsp_payload.param_valid, rsp_payload.param_index == 3'd0 && rsp_payload.param_value == 32'sd0, "parameter fields set without assignment")

   // Speed changes are only the two fixed steps or none.
   `RCBP_ASSERT_IMPL(a_speed_steps, rsp_valid, rsp_payload.speed_delta == 8'sd0 || rsp_payload.speed_delta == rcbp_pkg::SPEED_UP || rsp_payload.speed_delta == rcbp_pkg::SPEED_DOWN, "bad speed step")
endmodule

bind remote_command_byte_parser rcbp_checker u_rcbp_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_payload (rsp_ch.payload)
);

// ===== dv/testbench.sv =====
// ---------------------------------------------------------------------------
// Remote command byte parser testbench
// Sends command bytes and brace-framed parameter packets through the request
// channel and compares every response transaction, field by field, against
// the directed table's values or a behavioral model of the parser. A short
// directed table comes first, followed by random packet and command traffic
// with random idle cycles on both channels and one long response stall.
// ---------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import rcbp_pkg::*;

   localparam int PACKET_DEPTH = PACKET_DEPTH_DEFAULT;
   localparam int N_DIRECTED = 27;
   localparam int RANDOM_ITEMS = 1050;
   localparam int HOLD_AT = 300;
   localparam int HOLD_CYCLES = 400;

   typedef struct packed {
      logic [7:0]      rx;
      logic            typed;
      rsp_payload_type want;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rcbp_chan_if #(.payload_type(req_payload_type)) req_ch ();
   rcbp_chan_if #(.payload_type(rsp_payload_type)) rsp_ch ();

   remote_command_byte_parser #(
      .PACKET_DEPTH(PACKET_DEPTH)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Parser model state.
   logic               steering_sel = 1'b0;
   logic               spin_left_flag = 1'b0;
   logic               spin_right_flag = 1'b0;
   logic               in_packet = 1'b0;
   int                 kept_count = 0;
   logic [7:0]         pkt_id = '0;
   logic [7:0]         pkt_third = '0;
   logic signed [31:0] pkt_value = '0;
   logic               pkt_dropped = 1'b0;

   rsp_payload_type    expected_responses [$];
   directed_row_type   directed_rows [N_DIRECTED];
   int                 failures = 0;
   int                 bytes_offered = 0;
   int                 responses_taken = 0;
   int                 tx_run = 0;
   int                 rx_run = 0;
   bit                 tx_quiet = 1'b0;
   bit                 rx_quiet = 1'b0;

   function automatic rsp_payload_type decode_command_byte(input logic [7:0] b);
      rsp_payload_type r;
      longint          acc;
      r = '0;
      if (b == CH_STEER) begin
         steering_sel = 1'b1;
      end else if (b == CH_JOY_A || b == CH_JOY_B) begin
         steering_sel = 1'b0;
      end

      if (!steering_sel) begin
         if (b >= CH_DIR_FIRST && b <= CH_DIR_LAST) begin
            r.direction = 4'(b - CH_DIR_FIRST + 8'd1);
         end else if (b <= CH_RAW_LAST) begin
            r.direction = b[3:0];
         end
      end else begin
         spin_left_flag = (b == CH_SPIN_LEFT);
         spin_right_flag = (b == CH_SPIN_RIGHT);
         if (b == CH_DIR_FWD || b == CH_DIR_BACK) begin
            r.direction = 4'(b - CH_DIR_FIRST + 8'd1);
         end
      end

      if (b == CH_FAST) r.speed_delta = SPEED_UP;
      if (b == CH_SLOW) r.speed_delta = SPEED_DOWN;
      if (b == CH_OPEN) in_packet = 1'b1;

      if (b == CH_CLOSE) begin
         r.packet_overflow = pkt_dropped;
         if (pkt_third == CH_REPORT) begin
            r.report_request = 1'b1;
         end else if (pkt_id != CH_NOPARAM && pkt_id >= CH_ID_FIRST
                      && pkt_id <= CH_ID_LAST) begin
            r.param_valid = 1'b1;
            r.param_index = 3'(pkt_id - CH_ID_FIRST);
            r.param_value = pkt_value;
         end
         in_packet = 1'b0;
         kept_count = 0;
         pkt_id = '0;
         pkt_third = '0;
         pkt_value = '0;
         pkt_dropped = 1'b0;
      end else if (in_packet) begin
         if (kept_count < PACKET_DEPTH) begin
            if (kept_count == 1) pkt_id = b;
            if (kept_count == 3) pkt_third = b;
            if (kept_count >= 3) begin
               acc = longint'(pkt_value) * 10 + (longint'(b) - longint'(CH_DIGIT_ZERO));
               if (acc > 64'sd2147483647) acc = 64'sd2147483647;
               if (acc < -64'sd2147483648) acc = -64'sd2147483648;
               pkt_value = 32'(acc);
            end
            kept_count++;
         end else begin
            pkt_dropped = 1'b1;
         end
      end

      r.turn_mode = steering_sel;
      r.rotate_left = spin_left_flag;
      r.rotate_right = spin_right_flag;
      return r;
   endfunction

   // Idle cycles come in runs: some runs have none at all, in others each item draws its own random wait.
   function automatic int draw_wait(inout int run_left, inout bit quiet);
      if (run_left == 0) begin
         run_left = $urandom_range(8, 60);
         quiet = ($urandom_range(0, 3) == 0);
      end
      run_left--;
      return quiet ? 0 : $urandom_range(0, 8);
   endfunction

   function automatic directed_row_type drow(input logic [7:0] rx, input logic typed,
                                             input logic turn, input logic [3:0] dir,
                                             input logic rl, input logic rr,
                                             input logic signed [7:0] speed);
      directed_row_type row;
      row = '0;
      row.rx = rx;
      row.typed = typed;
      row.want.turn_mode = turn;
      row.want.direction = dir;
      row.want.rotate_left = rl;
      row.want.rotate_right = rr;
      row.want.speed_delta = speed;
      return row;
   endfunction

   function automatic logic [7:0] any_but_close();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      return (b == CH_CLOSE) ? CH_OPEN : b;
   endfunction

   task automatic compare_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         failures++;
      end
   endtask

   task automatic offer_byte(input logic [7:0] b, input logic typed,
                             input rsp_payload_type want);
      int              gap;
      rsp_payload_type predicted;
      gap = draw_wait(tx_run, tx_quiet);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= req_payload_type'(b);
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predicted = decode_command_byte(b);
      expected_responses.push_back(typed ? want : predicted);
      bytes_offered++;
   endtask

   initial begin
      int         pick;
      int         body_len;
      logic       negative;
      logic [7:0] burst [$];

      req_ch.valid <= 1'b0;
      req_ch.payload <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      directed_rows = '{
         drow(8'h00,         1'b1, 1'b0, 4'd0, 1'b0, 1'b0, 8'sd0),
         drow(CH_RAW_LAST,   1'b1, 1'b0, 4'd8, 1'b0, 1'b0, 8'sd0),
         drow(CH_DIR_LAST,   1'b1, 1'b0, 4'd8, 1'b0, 1'b0, 8'sd0),
         drow(8'hFF,         1'b1, 1'b0, 4'd0, 1'b0, 1'b0, 8'sd0),
         drow(CH_FAST,       1'b1, 1'b0, 4'd0, 1'b0, 1'b0, SPEED_UP),
         drow(CH_SLOW,       1'b1, 1'b0, 4'd0, 1'b0, 1'b0, SPEED_DOWN),
         // A closing brace with no packet open reports nothing.
         drow(CH_CLOSE,      1'b1, 1'b0, 4'd0, 1'b0, 1'b0, 8'sd0),
         drow(CH_STEER,      1'b1, 1'b1, 4'd0, 1'b0, 1'b0, 8'sd0),
         drow(CH_SPIN_RIGHT, 1'b1, 1'b1, 4'd0, 1'b0, 1'b1, 8'sd0),
         drow(CH_SPIN_LEFT,  1'b1, 1'b1, 4'd0, 1'b1, 1'b0, 8'sd0),
         drow(CH_DIR_BACK,   1'b1, 1'b1, 4'd5, 1'b0, 1'b0, 8'sd0),
         drow(CH_DIR_FWD,    1'b1, 1'b1, 4'd1, 1'b0, 1'b0, 8'sd0),
         drow(CH_JOY_A,      1'b1, 1'b0, 4'd0, 1'b0, 1'b0, 8'sd0),
         drow(CH_STEER,      1'b1, 1'b1, 4'd0, 1'b0, 1'b0, 8'sd0),
         // A second open brace inside a packet is kept as data.
         drow(CH_OPEN,       1'b0, 1'b0, 4'd0, 1'b0, 1'b0, 8'sd0),
         drow("7",           1'b0, 1'b0, 4'd0, 1'b0, 1'b0, 8'sd0),
         drow(CH_OPEN,       1'b0, 1'b0, 4'd0, 1'b0, 1'b0, 8'sd0),
         drow("5",           1'b0, 1'b0, 4'd0, 1'b0, 1'b0, 8'sd0),
         drow(CH_CLOSE,      1'b0, 1'b0, 4'd0, 1'b0, 1'b0, 8'sd0),
         // Short packet with an id that assigns nothing.
         drow(CH_OPEN,       1'b0, 1'b0, 4'd0, 1'b0, 1'b0, 8'sd0),
         drow(CH_NOPARAM,    1'b0, 1'b0, 4'd0, 1'b0, 1'b0, 8'sd0),
         drow(CH_CLOSE,      1'b0, 1'b0, 4'd0, 1'b0, 1'b0, 8'sd0),
         // Report request; the mode byte inside the packet still acts.
         drow(CH_OPEN,       1'b0, 1'b0, 4'd0, 1'b0, 1'b0, 8'sd0),
         drow("8",           1'b0, 1'b0, 4'd0, 1'b0, 1'b0, 8'sd0),
         drow(CH_JOY_B,      1'b0, 1'b0, 4'd0, 1'b0, 1'b0, 8'sd0),
         drow(CH_REPORT,     1'b0, 1'b0, 4'd0, 1'b0, 1'b0, 8'sd0),
         drow(CH_CLOSE,      1'b0, 1'b0, 4'd0, 1'b0, 1'b0, 8'sd0)
      };
      foreach (directed_rows[i]) begin
         offer_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].want);
      end

      while (bytes_offered < N_DIRECTED + RANDOM_ITEMS) begin
         burst.delete();
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            burst.push_back(CH_OPEN);
            case ($urandom_range(0, 7))
               0: begin
                  burst.push_back(CH_NOPARAM);
               end
               1: begin
                  burst.push_back("8");
               end
               2: begin
                  burst.push_back(any_but_close());
               end
               default: begin
                  burst.push_back(CH_ID_FIRST + 8'($urandom_range(0, 7)));
               end
            endcase
            burst.push_back(any_but_close());
            // Mostly short values, sometimes ones that saturate or overrun the buffer.
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
               body_len = $urandom_range(PACKET_DEPTH - 6, PACKET_DEPTH + 2);
            end else if (pick == 1) begin
               body_len = $urandom_range(10, 14);
            end else begin
               body_len = $urandom_range(0, 6);
            end
            negative = 1'($urandom_range(0, 1));
            for (int i = 0; i < body_len; i++) begin
               if (i == 0 && $urandom_range(0, 4) == 0) begin
                  burst.push_back(CH_REPORT);
               end else if (pick == 1) begin
                  burst.push_back(negative ? 8'($urandom_range(0, CH_DIGIT_ZERO - 1)) : "9");
               end else if ($urandom_range(0, 4) == 0) begin
                  burst.push_back(any_but_close());
               end else begin
                  burst.push_back(CH_DIGIT_ZERO + 8'($urandom_range(0, 9)));
               end
            end
            // Now and then a packet is left open and later bytes run into it.
            if ($urandom_range(0, 9) != 0) burst.push_back(CH_CLOSE);
         end else begin
            case ($urandom_range(0, 3))
               0: begin
                  burst.push_back(8'($urandom_range(0, 255)));
               end
               1: begin
                  burst.push_back(CH_DIR_FIRST + 8'($urandom_range(0, 7)));
               end
               2: begin
                  burst.push_back(8'($urandom_range(0, CH_RAW_LAST)));
               end
               default: begin
                  case ($urandom_range(0, 5))
                     0: burst.push_back(CH_STEER);
                     1: burst.push_back(CH_JOY_A);
                     2: burst.push_back(CH_JOY_B);
                     3: burst.push_back(CH_FAST);
                     4: burst.push_back(CH_SLOW);
                     default: burst.push_back(CH_CLOSE);
                  endcase
               end
            endcase
         end
         foreach (burst[i]) offer_byte(burst[i], 1'b0, '0);
      end

      req_ch.valid <= 1'b0;
      while (expected_responses.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (failures == 0) begin
         $display("remote_command_byte_parser verification clean");
      end else begin
         $display("remote_command_byte_parser verification failed");
      end
      $finish;
   end

   // Response side: random stalls, plus one long hold-off so the parser
   // fills up and pushes back on the request channel.
   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (responses_taken == HOLD_AT) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         stall = draw_wait(rx_run, rx_quiet);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         responses_taken++;
      end
   end

   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_responses.size() == 0) begin
            $error("response transaction with no byte outstanding");
            failures++;
         end else begin
            want = expected_responses.pop_front();
            compare_field("turn_mode", want.turn_mode, rsp_ch.payload.turn_mode);
            compare_field("direction", want.direction, rsp_ch.payload.direction);
            compare_field("rotate_left", want.rotate_left, rsp_ch.payload.rotate_left);
            compare_field("rotate_right", want.rotate_right, rsp_ch.payload.rotate_right);
            compare_field("speed_delta", want.speed_delta, rsp_ch.payload.speed_delta);
            compare_field("report_request", want.report_request,
                          rsp_ch.payload.report_request);
            compare_field("param_valid", want.param_valid, rsp_ch.payload.param_valid);
            compare_field("param_index", want.param_index, rsp_ch.payload.param_index);
            compare_field("param_value", want.param_value, rsp_ch.payload.param_value);
            compare_field("packet_overflow", want.packet_overflow,
                          rsp_ch.payload.packet_overflow);
         end
      end
   end

   initial begin
      #2_000_000;
      $display("remote_command_byte_parser verification failed");
      $finish;
   end

endmodule
